### rtl/mhpq_pkg.sv
`timescale 1ns / 1ps

package mhpq_pkg;

	// Heap geometry and field widths.
	localparam int CAPACITY = 256;
	localparam int KEY_W    = 32;
	localparam int SYM_W    = 8;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CHILD_W  = IDX_W + 2;
	localparam int FILL_W   = 9;
	localparam int ENTRY_W  = SYM_W + KEY_W;

	// Operation codes carried in the func field.
	localparam logic FUNC_INSERT  = 1'b0;
	localparam logic FUNC_EXTRACT = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic        func;
		logic [7:0]  symbol;
		logic [31:0] weight;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  min_symbol;
		logic [31:0] min_weight;
		logic [8:0]  fill;
	} rsp_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic [KEY_W-1:0] weight;
	} entry_t;

	// Read address selection: ENDS reads the root on port A and the last entry on port B.
	typedef enum logic [1:0] {
		RD_ENDS,
		RD_PARENT,
		RD_CHILDREN
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_ENTRY,
		WR_PARENT,
		WR_CHILD
	} wr_sel_t;

	typedef struct packed {
		logic    load_item;
		logic    ins_start;
		logic    set_full;
		logic    set_empty;
		logic    ext_load;
		logic    cap_root;
		logic    move_up;
		logic    move_down;
		logic    emit;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
	} cmd_t;

	typedef struct packed {
		logic extract;
		logic empty;
		logic full;
		logic pos_zero;
		logic left_out;
		logic parent_gt;
		logic child_lt;
	} sts_t;

endpackage

### rtl/min_heap_priority_queue_unit.sv
`timescale 1ns / 1ps

// Binary min-heap priority queue of up to 256 (symbol, weight) entries.
// Request channel (req_valid, req_stall, req): each item is either an insert of
// an entry or an extract of the minimum entry. An item is taken on a rising
// edge with req_valid high and req_stall low. Response channel (rsp_valid,
// rsp_stall, rsp): every request item yields exactly one response item carrying
// a status (ok, full, empty), the extracted entry or the root after an insert,
// and the number of entries held afterwards.
// One item is worked on at a time; the sift loop runs over a RAM with one write port
// and two registered read ports. The next item can be taken in the cycle after the
// response is loaded.
// The response sits in an output register, so a new request is accepted while
// the previous response still waits; when the receiver holds rsp_stall high the
// block finishes its current item and then waits with that result until the
// output register is free, holding req_stall high meanwhile.
// Reset empties the heap at once by clearing the entry count; RAM contents are
// not cleared because only entries below the count are ever used.
module min_heap_priority_queue_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  mhpq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output mhpq_pkg::rsp_t rsp
);

	mhpq_pkg::cmd_t cmd;
	mhpq_pkg::sts_t sts;

	// The controller sequences sift steps; the datapath holds the heap state.
	mhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mhpq_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

### rtl/mhpq_ram.sv
`timescale 1ns / 1ps

// Simple dual-read, single-write RAM with registered read data.
module mhpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr_a,
	output logic [WIDTH-1:0] rd_data_a,
	input  logic [AW-1:0]    rd_addr_b,
	output logic [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

### rtl/mhpq_datapath.sv
`timescale 1ns / 1ps

// Heap storage, hole position, entry count, moving entry and result register.
module mhpq_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  mhpq_pkg::req_t  req,
	input  mhpq_pkg::cmd_t  cmd,
	output mhpq_pkg::sts_t  sts,
	output mhpq_pkg::rsp_t  rsp
);

	logic                         func_q;
	mhpq_pkg::entry_t             e_q;
	mhpq_pkg::entry_t             res_q;
	mhpq_pkg::status_t            status_q;
	logic [mhpq_pkg::IDX_W-1:0]   pos_q;
	logic [mhpq_pkg::CNT_W-1:0]   cnt_q;
	mhpq_pkg::rsp_t               rsp_q;

	logic [mhpq_pkg::ENTRY_W-1:0] rd_a_raw;
	logic [mhpq_pkg::ENTRY_W-1:0] rd_b_raw;
	mhpq_pkg::entry_t             rd_a;
	mhpq_pkg::entry_t             rd_b;
	mhpq_pkg::entry_t             best;
	mhpq_pkg::entry_t             wr_entry;
	logic [mhpq_pkg::CHILD_W-1:0] left_w;
	logic [mhpq_pkg::CHILD_W-1:0] right_w;
	logic [mhpq_pkg::CHILD_W-1:0] cnt_ext;
	logic [mhpq_pkg::IDX_W-1:0]   pos_m1;
	logic [mhpq_pkg::IDX_W-1:0]   parent_idx;
	logic [mhpq_pkg::CNT_W-1:0]   cnt_dec;
	logic [mhpq_pkg::IDX_W-1:0]   last_idx;
	logic [mhpq_pkg::IDX_W-1:0]   best_idx;
	logic [mhpq_pkg::IDX_W-1:0]   rd_addr_a;
	logic [mhpq_pkg::IDX_W-1:0]   rd_addr_b;
	logic                         right_ok;
	logic                         pick_right;
	logic                         wr_en;

	assign rd_a = rd_a_raw;
	assign rd_b = rd_b_raw;

	// Child positions 2p+1 and 2p+2 are kept one bit wider than the count.
	assign left_w     = {1'b0, pos_q, 1'b1};
	assign right_w    = left_w + mhpq_pkg::CHILD_W'(1);
	assign cnt_ext    = mhpq_pkg::CHILD_W'(cnt_q);
	assign pos_m1     = pos_q - mhpq_pkg::IDX_W'(1);
	assign parent_idx = {1'b0, pos_m1[mhpq_pkg::IDX_W-1:1]};
	assign cnt_dec    = cnt_q - mhpq_pkg::CNT_W'(1);
	assign last_idx   = cnt_dec[mhpq_pkg::IDX_W-1:0];

	// The left child wins a tie between the children.
	assign right_ok   = right_w < cnt_ext;
	assign pick_right = right_ok && (rd_b.weight < rd_a.weight);
	assign best       = pick_right ? rd_b : rd_a;
	assign best_idx   = pick_right ? right_w[mhpq_pkg::IDX_W-1:0]
	                               : left_w[mhpq_pkg::IDX_W-1:0];

	always_comb begin
		case (cmd.rd_sel)
			mhpq_pkg::RD_PARENT: begin
				rd_addr_a = parent_idx;
				rd_addr_b = last_idx;
			end
			mhpq_pkg::RD_CHILDREN: begin
				rd_addr_a = left_w[mhpq_pkg::IDX_W-1:0];
				rd_addr_b = right_w[mhpq_pkg::IDX_W-1:0];
			end
			default: begin
				rd_addr_a = '0;
				rd_addr_b = last_idx;
			end
		endcase
	end

	always_comb begin
		case (cmd.wr_sel)
			mhpq_pkg::WR_PARENT: wr_entry = rd_a;
			mhpq_pkg::WR_CHILD:  wr_entry = best;
			default:             wr_entry = e_q;
		endcase
	end

	assign wr_en = cmd.wr_sel != mhpq_pkg::WR_NONE;

	mhpq_ram #(
		.WIDTH(mhpq_pkg::ENTRY_W),
		.DEPTH(mhpq_pkg::CAPACITY)
	) u_heap_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (pos_q),
		.wr_data   (wr_entry),
		.rd_addr_a (rd_addr_a),
		.rd_data_a (rd_a_raw),
		.rd_addr_b (rd_addr_b),
		.rd_data_b (rd_b_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.ins_start) begin
			cnt_q <= cnt_q + mhpq_pkg::CNT_W'(1);
		end else if (cmd.ext_load) begin
			cnt_q <= cnt_dec;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			func_q      <= req.func;
			e_q.symbol  <= req.symbol;
			e_q.weight  <= mhpq_pkg::KEY_W'(req.weight);
			status_q    <= mhpq_pkg::ST_OK;
		end
		if (cmd.ins_start) begin
			pos_q <= cnt_q[mhpq_pkg::IDX_W-1:0];
		end
		if (cmd.set_full) begin
			status_q <= mhpq_pkg::ST_FULL;
		end
		if (cmd.set_empty) begin
			status_q <= mhpq_pkg::ST_EMPTY;
			res_q    <= '0;
		end
		if (cmd.ext_load) begin
			res_q <= rd_a;
			e_q   <= rd_b;
			pos_q <= '0;
		end
		if (cmd.cap_root) begin
			res_q <= rd_a;
		end
		if (cmd.move_up) begin
			pos_q <= parent_idx;
		end
		if (cmd.move_down) begin
			pos_q <= best_idx;
		end
		if (cmd.emit) begin
			rsp_q.status     <= status_q;
			rsp_q.min_symbol <= res_q.symbol;
			rsp_q.min_weight <= 32'(res_q.weight);
			rsp_q.fill       <= mhpq_pkg::FILL_W'(cnt_q);
		end
	end

	assign sts.extract   = func_q == mhpq_pkg::FUNC_EXTRACT;
	assign sts.empty     = cnt_q == '0;
	assign sts.full      = cnt_q == mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY);
	assign sts.pos_zero  = pos_q == '0;
	assign sts.left_out  = left_w >= cnt_ext;
	assign sts.parent_gt = rd_a.weight > e_q.weight;
	assign sts.child_lt  = best.weight < e_q.weight;

	assign rsp = rsp_q;

endmodule

### rtl/mhpq_ctrl.sv
`timescale 1ns / 1ps

// Sequencer for insert with sift-up and extract with sift-down.
module mhpq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	input  mhpq_pkg::sts_t sts,
	output mhpq_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_UP_CHK,
		S_UP_CMP,
		S_ROOT_RD,
		S_ROOT_CAP,
		S_DN_LOAD,
		S_DN_CHK,
		S_DN_CMP,
		S_RESP
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   rsp_free;

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.extract) begin
					if (sts.empty) begin
						cmd.set_empty = 1'b1;
						state_d       = S_RESP;
					end else begin
						cmd.rd_sel = mhpq_pkg::RD_ENDS;
						state_d    = S_DN_LOAD;
					end
				end else if (sts.full) begin
					cmd.set_full = 1'b1;
					state_d      = S_ROOT_RD;
				end else begin
					cmd.ins_start = 1'b1;
					state_d       = S_UP_CHK;
				end
			end
			S_UP_CHK: begin
				if (sts.pos_zero) begin
					cmd.wr_sel = mhpq_pkg::WR_ENTRY;
					state_d    = S_ROOT_RD;
				end else begin
					cmd.rd_sel = mhpq_pkg::RD_PARENT;
					state_d    = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (sts.parent_gt) begin
					cmd.wr_sel  = mhpq_pkg::WR_PARENT;
					cmd.move_up = 1'b1;
					state_d     = S_UP_CHK;
				end else begin
					cmd.wr_sel = mhpq_pkg::WR_ENTRY;
					state_d    = S_ROOT_RD;
				end
			end
			S_ROOT_RD: begin
				cmd.rd_sel = mhpq_pkg::RD_ENDS;
				state_d    = S_ROOT_CAP;
			end
			S_ROOT_CAP: begin
				cmd.cap_root = 1'b1;
				state_d      = S_RESP;
			end
			S_DN_LOAD: begin
				cmd.ext_load = 1'b1;
				state_d      = S_DN_CHK;
			end
			S_DN_CHK: begin
				if (sts.left_out) begin
					cmd.wr_sel = mhpq_pkg::WR_ENTRY;
					state_d    = S_RESP;
				end else begin
					cmd.rd_sel = mhpq_pkg::RD_CHILDREN;
					state_d    = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				if (sts.child_lt) begin
					cmd.wr_sel    = mhpq_pkg::WR_CHILD;
					cmd.move_down = 1'b1;
					state_d       = S_DN_CHK;
				end else begin
					cmd.wr_sel = mhpq_pkg::WR_ENTRY;
					state_d    = S_RESP;
				end
			end
			S_RESP: begin
				if (rsp_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

### test/min_heap_priority_queue_unit_tb.sv
`timescale 1ns / 1ps

module min_heap_priority_queue_unit_tb;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 4;
	localparam int RANDOM_ITEMS = 1800;
	// Length of the one long receiver hold-off, in clock cycles.
	localparam int LONG_HOLD    = 400;
	// Extra cycles after the last result, so that a stray result still shows up.
	localparam int TAIL_CYCLES  = 60;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int TIMEOUT_NS   = 12_000_000;

	// Shadow copy of the heap. Every accepted request item is applied to it at
	// once, and the result that the block must return for that item is queued.
	// Results come back in request order, so the oldest queued result is the
	// one that the next response item is compared with.
	class heap_shadow;
		logic [mhpq_pkg::SYM_W-1:0] slot_symbol [mhpq_pkg::CAPACITY];
		logic [mhpq_pkg::KEY_W-1:0] slot_weight [mhpq_pkg::CAPACITY];
		int unsigned held;
		mhpq_pkg::rsp_t awaited [$];
		int unsigned errors;

		function new();
			held = 0;
			errors = 0;
		endfunction

		function void swap_slots(int unsigned a, int unsigned b);
			logic [mhpq_pkg::SYM_W-1:0] sym;
			logic [mhpq_pkg::KEY_W-1:0] wgt;
			sym = slot_symbol[a];
			wgt = slot_weight[a];
			slot_symbol[a] = slot_symbol[b];
			slot_weight[a] = slot_weight[b];
			slot_symbol[b] = sym;
			slot_weight[b] = wgt;
		endfunction

		// A new entry climbs only past a parent with a strictly larger weight.
		function void sift_up(int unsigned start);
			int unsigned pos;
			int unsigned parent;
			bit done;
			pos = start;
			done = 1'b0;
			while (pos > 0 && !done) begin
				parent = (pos - 1) / 2;
				if (slot_weight[parent] > slot_weight[pos]) begin
					swap_slots(pos, parent);
					pos = parent;
				end else begin
					done = 1'b1;
				end
			end
		endfunction

		// The root sinks toward the smaller child; the left child wins a tie, and
		// an equal child is never swapped with.
		function void sift_down();
			int unsigned pos;
			int unsigned left;
			int unsigned right;
			int unsigned best;
			bit done;
			pos = 0;
			done = 1'b0;
			while (!done) begin
				left = 2 * pos + 1;
				right = 2 * pos + 2;
				best = pos;
				if (left < held && slot_weight[left] < slot_weight[best])
					best = left;
				if (right < held && slot_weight[right] < slot_weight[best])
					best = right;
				if (best == pos) begin
					done = 1'b1;
				end else begin
					swap_slots(pos, best);
					pos = best;
				end
			end
		endfunction

		function void note_request(mhpq_pkg::req_t item);
			mhpq_pkg::rsp_t want;
			want = '0;
			want.status = mhpq_pkg::ST_OK;
			if (item.func == mhpq_pkg::FUNC_INSERT) begin
				// A full heap drops the entry but still reports the root.
				if (held >= mhpq_pkg::CAPACITY) begin
					want.status = mhpq_pkg::ST_FULL;
				end else begin
					slot_symbol[held] = item.symbol;
					slot_weight[held] = item.weight[mhpq_pkg::KEY_W-1:0];
					held++;
					sift_up(held - 1);
				end
				if (held > 0) begin
					want.min_symbol = slot_symbol[0];
					want.min_weight = slot_weight[0];
				end
			end else if (held == 0) begin
				// Extract from an empty heap: zero entry, nothing changes.
				want.status = mhpq_pkg::ST_EMPTY;
			end else begin
				want.min_symbol = slot_symbol[0];
				want.min_weight = slot_weight[0];
				held--;
				slot_symbol[0] = slot_symbol[held];
				slot_weight[0] = slot_weight[held];
				if (held > 0)
					sift_down();
			end
			want.fill = held[mhpq_pkg::FILL_W-1:0];
			awaited = {awaited, want};
		endfunction

		// Prints one line per mismatch and counts it. Printing stops after a
		// while so that a broken block does not flood the log; counting does not.
		task report(string what);
			errors++;
			if (errors <= 50)
				$display("mismatch at %0t ns: %s", $time, what);
		endtask

		task check_result(mhpq_pkg::rsp_t got);
			mhpq_pkg::rsp_t want;
			if (awaited.size() == 0) begin
				report($sformatf("result with none expected: status %0d symbol %h weight %h fill %0d",
					got.status, got.min_symbol, got.min_weight, got.fill));
			end else begin
				want = awaited.pop_front();
				if (got.status !== want.status)
					report($sformatf("status %0d, expected %0d", got.status, want.status));
				if (got.min_symbol !== want.min_symbol)
					report($sformatf("min_symbol %h, expected %h", got.min_symbol,
						want.min_symbol));
				if (got.min_weight !== want.min_weight)
					report($sformatf("min_weight %h, expected %h", got.min_weight,
						want.min_weight));
				if (got.fill !== want.fill)
					report($sformatf("fill %0d, expected %0d", got.fill, want.fill));
			end
		endtask

		function int unsigned outstanding();
			return awaited.size();
		endfunction

		function int unsigned entries();
			return held;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	mhpq_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	mhpq_pkg::rsp_t rsp;

	heap_shadow shadow;

	// While calm is set neither side takes random idle time. hold_request asks the receiver for
	// its long hold-off, and hold_active tells that the hold-off has begun.
	bit calm;
	bit hold_request;
	bit hold_active;
	int unsigned items_sent;

	min_heap_priority_queue_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Both channels are sampled at the rising edge. All inputs change by
	// nonblocking assignment at that same edge, so the values seen here are the
	// ones the block saw. A result is checked before the request of the same
	// edge is applied; the result always belongs to an older request.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (rsp_valid && !rsp_stall)
				shadow.check_result(rsp);
			if (req_valid && !req_stall)
				shadow.note_request(req);
		end
	end

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int unsigned idle_len();
		int unsigned roll;
		int unsigned len;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55)
			len = 0;
		else if (roll < 88)
			len = $urandom_range(1, 3);
		else if (roll < 97)
			len = $urandom_range(4, 15);
		else
			len = $urandom_range(20, 60);
		return len;
	endfunction

	// Weights lean toward the extremes, a few small values and single-bit values, so that
	// ties are common; the rest are spread over the full range. With ties set, all fall in 0 to 3.
	function automatic logic [31:0] pick_weight(bit ties);
		logic [31:0] wgt;
		case ($urandom_range(0, 9))
			0: wgt = '0;
			1: wgt = '1;
			2, 3: wgt = $urandom_range(0, 7);
			4: wgt = 32'd1 << $urandom_range(0, 31);
			default: wgt = $urandom();
		endcase
		if (ties)
			wgt = $urandom_range(0, 3);
		return wgt;
	endfunction

	function automatic mhpq_pkg::req_t make_insert(logic [7:0] sym, logic [31:0] wgt);
		mhpq_pkg::req_t item;
		item.func = mhpq_pkg::FUNC_INSERT;
		item.symbol = sym;
		item.weight = wgt;
		return item;
	endfunction

	// The payload of an extract item is ignored by the block but still varies.
	function automatic mhpq_pkg::req_t make_extract();
		mhpq_pkg::req_t item;
		item.func = mhpq_pkg::FUNC_EXTRACT;
		item.symbol = 8'($urandom_range(0, 255));
		item.weight = $urandom();
		return item;
	endfunction

	// Offers one item and holds it until it is accepted. With no idle time
	// after it, valid stays high and the caller must offer the next item or
	// lower valid in the same time step.
	task automatic send_item(input mhpq_pkg::req_t item);
		int unsigned gap;
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		items_sent++;
		gap = idle_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// The sender pauses until every expected result has come back. One edge
	// passes first so that the last accepted item has surely been noted.
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (shadow.outstanding() != 0)
			@(posedge clk);
	endtask

	// Receiver: alternates runs of ready cycles with stalls of random length.
	// On request it holds stall high through its long hold-off, so that the block
	// fills its output register and then stalls its own input.
	initial begin : receiver
		int unsigned run;
		int unsigned stall;
		rsp_stall <= 1'b0;
		hold_active = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				hold_active = 1'b1;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_active = 1'b0;
			end else begin
				stall = idle_len();
				if (stall > 0) begin
					rsp_stall <= 1'b1;
					repeat (stall) @(posedge clk);
				end
				rsp_stall <= 1'b0;
				run = $urandom_range(1, 12);
				repeat (run) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int unsigned start;
		int unsigned phase;
		int unsigned span;
		int unsigned insert_pct;
		int unsigned k;
		bit ties;

		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		calm = 1'b0;
		hold_request = 1'b0;
		items_sent = 0;
		shadow = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. An extract from the empty heap comes first. Then the
		// extreme weights and symbols go in, with a zero weight arriving on top of
		// an equal root and two entries of equal weight; draining them walks every
		// sift-down path down to the removal of the last entry, and one more
		// extract hits the empty heap again. The last group sets up a sinking root whose
		// only child has an equal weight.
		send_item(make_extract());
		send_item(make_insert(8'hA5, 32'hFFFF_FFFF));
		send_item(make_insert(8'h00, 32'h0000_0000));
		send_item(make_insert(8'hFF, 32'h0000_0000));
		send_item(make_insert(8'h5A, 32'h8000_0000));
		send_item(make_insert(8'h3C, 32'h7FFF_FFFF));
		send_item(make_insert(8'hC3, 32'h7FFF_FFFF));
		repeat (7) send_item(make_extract());
		send_item(make_insert(8'h55, 32'hAAAA_AAAA));
		send_item(make_insert(8'hAA, 32'h5555_5555));
		send_item(make_insert(8'h81, 32'hAAAA_AAAA));
		repeat (3) send_item(make_extract());
		wait_drained();

		// Random part, in phases of varying mix. One phase fills the heap to
		// capacity, pushes inserts into the full heap and then drains it past
		// empty; another runs against the long receiver hold-off.
		start = items_sent;
		phase = 0;
		while (items_sent - start < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 3) == 0);
			ties = ($urandom_range(0, 4) == 0);
			span = $urandom_range(20, 120);
			case ($urandom_range(0, 3))
				0: insert_pct = 50;
				1: insert_pct = 80;
				2: insert_pct = 25;
				default: insert_pct = 60;
			endcase

			if (phase == 2) begin
				wait_drained();
				hold_request = 1'b1;
				while (!hold_active)
					@(posedge clk);
				calm = 1'b1;
				for (k = 0; k < 30; k++)
					send_item(make_insert(8'($urandom_range(0, 255)), pick_weight(ties)));
			end else if (phase == 4) begin
				while (shadow.entries() < mhpq_pkg::CAPACITY)
					send_item(make_insert(8'($urandom_range(0, 255)), pick_weight(ties)));
				repeat (6)
					send_item(make_insert(8'($urandom_range(0, 255)), pick_weight(ties)));
				while (shadow.entries() > 0)
					send_item(make_extract());
				repeat (4) send_item(make_extract());
			end else begin
				for (k = 0; k < span; k++) begin
					if ($urandom_range(0, 99) < insert_pct)
						send_item(make_insert(8'($urandom_range(0, 255)),
							pick_weight(ties)));
					else
						send_item(make_extract());
				end
			end

			// Now and then, and always after the hold-off, the sender waits
			// for every outstanding result before going on.
			if (phase == 2 || $urandom_range(0, 3) == 0)
				wait_drained();
			phase++;
		end

		// Wait for the last results, then a few more cycles for anything extra.
		calm = 1'b0;
		req_valid <= 1'b0;
		@(posedge clk);
		k = 0;
		while (shadow.outstanding() != 0 && k < DRAIN_LIMIT) begin
			@(posedge clk);
			k++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (shadow.outstanding() != 0)
			shadow.report($sformatf("%0d results never arrived", shadow.outstanding()));
		if (shadow.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
